### src/nsm_pkg.sv
`timescale 1ns / 1ps

package nsm_pkg;

    // Fixed field widths
    localparam int STATE_W     = 4;
    localparam int SET_W       = 16;
    localparam int INDEX_W     = 6;
    localparam int SYMBOL_W    = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_STATE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTING   = 1'b1;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_WRITE_ENTRY = 2'd0,
        OP_WRITE_EPS   = 2'd1,
        OP_SYMBOL      = 2'd2,
        OP_FINISH      = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_DONE
    } t_state;

    // Input item payload, lowest field in the lowest bits
    typedef struct packed {
        logic                pad;
        logic [SET_W-1:0]    epsilon_targets;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  to_state;
        logic [STATE_W-1:0]  from_state;
        logic                entry_valid;
        logic [INDEX_W-1:0]  entry_index;
    } t_in_data;

    // Result item payload
    typedef struct packed {
        logic [6:0]       pad;
        logic [SET_W-1:0] final_states;
        logic             matched;
    } t_out_data;

    // One labelled transition entry
    typedef struct packed {
        logic                valid;
        logic [STATE_W-1:0]  from_state;
        logic [STATE_W-1:0]  to_state;
        logic [SYMBOL_W-1:0] label;
    } t_entry;

endpackage

### src/nfa_string_matcher_core.sv
`timescale 1ns / 1ps

// Table writes are done from idle; a finish item loads the result register once it is free.
// A symbol item is accepted, then scans the table, then sweeps the epsilon masks until a
// sweep adds no state. The first symbol or finish of a string first builds the closure of
// the start state the same way. One item at a time: s_axis_tready stays low while busy.
// Synchronous active-low reset, then a pass that clears the table.
module nfa_string_matcher_core #(
    parameter int NUM_STATES      = 16,
    parameter int NUM_TRANSITIONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nsm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, entry_valid, from_state, to_state, symbol, epsilon_targets
    input  logic [nsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic [1:0]                          s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // matched, final_states
    output logic [nsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;

    // Storage
    nsm_pkg::t_entry         tbl_mem [NUM_TRANSITIONS];
    logic [NUM_STATES-1:0]   eps_mem [NUM_STATES];

    // Control registers
    nsm_pkg::t_state         r_state, n_state;
    logic [TW-1:0]           r_tcnt;
    logic                    r_tv, r_tl;
    logic [SW-1:0]           r_scnt, r_eidx;
    logic                    r_ev, r_el, r_chg;
    logic                    r_open, r_opening;
    nsm_pkg::t_op            r_op;
    logic                    r_mvld;
    logic [nsm_pkg::STATE_W-1:0] r_start;
    logic [nsm_pkg::SET_W-1:0]   r_accept;
    logic [NUM_STATES-1:0]   r_eps_vld;
    logic [NUM_STATES-1:0]   r_set, r_next;

    // Payload registers
    logic [nsm_pkg::SYMBOL_W-1:0] r_sym;
    nsm_pkg::t_entry         r_tq;
    logic [NUM_STATES-1:0]   r_eps_q;
    logic                    r_eps_qv;
    nsm_pkg::t_out_data      r_mdata;

    // Combinational
    nsm_pkg::t_in_data       w_in;
    nsm_pkg::t_op            w_op;
    logic                    w_in_acc, w_out_free;
    logic                    w_tlast, w_slast;
    logic                    w_tbl_we, w_eps_we;
    logic [TW-1:0]           w_tbl_addr;
    nsm_pkg::t_entry         w_tbl_wdata;
    logic [SW-1:0]           w_eps_addr;
    logic [NUM_STATES-1:0]   w_start_bit, w_tbit, w_emask, w_add, w_acc_set;
    logic                    w_thit, w_grow, w_close_end;

    assign w_in       = nsm_pkg::t_in_data'(s_axis_tdata);
    assign w_op       = nsm_pkg::t_op'(s_axis_tuser);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_mvld || m_axis_tready;
    assign w_tlast    = (r_tcnt == TW'(NUM_TRANSITIONS - 1));
    assign w_slast    = (r_scnt == SW'(NUM_STATES - 1));
    assign w_start_bit = NUM_STATES'(1) << r_start;
    assign w_acc_set  = NUM_STATES'(r_accept);

    // Evaluate one fetched transition entry against the active set
    assign w_thit = r_tq.valid && (r_tq.label == r_sym)
                    && (|(r_set & (NUM_STATES'(1) << r_tq.from_state)));
    assign w_tbit = w_thit ? (NUM_STATES'(1) << r_tq.to_state) : '0;

    // Add the epsilon successors of one active state
    assign w_emask     = r_eps_qv ? r_eps_q : '0;
    assign w_add       = r_set[r_eidx] ? (w_emask & ~r_set) : '0;
    assign w_grow      = |w_add;
    assign w_close_end = r_ev && r_el && !r_chg && !w_grow;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nsm_pkg::ST_CLEAR: begin
                if (w_tlast) n_state = nsm_pkg::ST_IDLE;
            end
            nsm_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if ((w_op == nsm_pkg::OP_SYMBOL) || (w_op == nsm_pkg::OP_FINISH)) begin
                        if (!r_open) n_state = nsm_pkg::ST_CLOSE;
                        else if (w_op == nsm_pkg::OP_SYMBOL) n_state = nsm_pkg::ST_SCAN;
                        else n_state = nsm_pkg::ST_DONE;
                    end
                end
            end
            nsm_pkg::ST_SCAN: begin
                if (r_tv && r_tl) n_state = nsm_pkg::ST_CLOSE;
            end
            nsm_pkg::ST_CLOSE: begin
                if (w_close_end) begin
                    if (r_opening && (r_op == nsm_pkg::OP_SYMBOL)) n_state = nsm_pkg::ST_SCAN;
                    else if (r_opening) n_state = nsm_pkg::ST_DONE;
                    else n_state = nsm_pkg::ST_IDLE;
                end
            end
            nsm_pkg::ST_DONE: begin
                if (w_out_free) n_state = nsm_pkg::ST_IDLE;
            end
            default: n_state = nsm_pkg::ST_CLEAR;
        endcase
    end

    // Handshakes and memory write controls
    always_comb begin
        s_axis_tready = (r_state == nsm_pkg::ST_IDLE);
        o_cfg_ready   = 1'b1;
        m_axis_tvalid = r_mvld;
        m_axis_tdata  = r_mdata;
        w_tbl_we      = 1'b0;
        w_tbl_addr    = r_tcnt;
        w_tbl_wdata   = '0;
        w_eps_we      = 1'b0;
        w_eps_addr    = SW'(w_in.from_state);
        case (r_state)
            nsm_pkg::ST_CLEAR: begin
                w_tbl_we = 1'b1;
            end
            nsm_pkg::ST_IDLE: begin
                if (w_in_acc && (w_op == nsm_pkg::OP_WRITE_ENTRY)
                    && (32'(w_in.entry_index) < NUM_TRANSITIONS)) begin
                    w_tbl_we    = 1'b1;
                    w_tbl_addr  = TW'(w_in.entry_index);
                    w_tbl_wdata = '{valid: w_in.entry_valid, from_state: w_in.from_state,
                                    to_state: w_in.to_state, label: w_in.symbol};
                end
                if (w_in_acc && (w_op == nsm_pkg::OP_WRITE_EPS)
                    && (32'(w_in.from_state) < NUM_STATES)) begin
                    w_eps_we = 1'b1;
                end
            end
            default: begin
                w_tbl_we = 1'b0;
            end
        endcase
    end

    // Transition table and epsilon mask memories
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) tbl_mem[w_tbl_addr] <= w_tbl_wdata;
        if (w_eps_we) eps_mem[w_eps_addr] <= NUM_STATES'(w_in.epsilon_targets);
        r_tq     <= tbl_mem[r_tcnt];
        r_eps_q  <= eps_mem[r_scnt];
        r_eps_qv <= r_eps_vld[r_scnt];
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nsm_pkg::ST_CLEAR;
            r_tcnt    <= '0;
            r_tv      <= 1'b0;
            r_tl      <= 1'b0;
            r_scnt    <= '0;
            r_eidx    <= '0;
            r_ev      <= 1'b0;
            r_el      <= 1'b0;
            r_chg     <= 1'b0;
            r_open    <= 1'b0;
            r_opening <= 1'b0;
            r_op      <= nsm_pkg::OP_SYMBOL;
            r_mvld    <= 1'b0;
            r_start   <= '0;
            r_accept  <= '0;
            r_eps_vld <= '0;
            r_set     <= '0;
            r_next    <= '0;
        end else begin
            r_state <= n_state;

            // Configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    nsm_pkg::REG_START_STATE: r_start  <= i_cfg_data[nsm_pkg::STATE_W-1:0];
                    nsm_pkg::REG_ACCEPTING:   r_accept <= i_cfg_data;
                    default:                  r_accept <= r_accept;
                endcase
            end

            // Drop the result once taken
            if (r_mvld && m_axis_tready) r_mvld <= 1'b0;

            case (r_state)
                nsm_pkg::ST_CLEAR: begin
                    r_tcnt <= w_tlast ? '0 : r_tcnt + TW'(1);
                end
                nsm_pkg::ST_IDLE: begin
                    if (w_eps_we) r_eps_vld[w_eps_addr] <= 1'b1;
                    if (w_in_acc && ((w_op == nsm_pkg::OP_SYMBOL)
                                     || (w_op == nsm_pkg::OP_FINISH))) begin
                        r_op  <= w_op;
                        r_sym <= w_in.symbol;
                        if (!r_open) begin
                            // open the string on the closure of the start state
                            r_set     <= w_start_bit;
                            r_open    <= 1'b1;
                            r_opening <= 1'b1;
                            r_scnt    <= '0;
                            r_ev      <= 1'b0;
                            r_chg     <= 1'b0;
                        end else begin
                            r_tcnt <= '0;
                            r_tv   <= 1'b0;
                            r_next <= '0;
                        end
                    end
                end
                nsm_pkg::ST_SCAN: begin
                    // advance through the table, one entry a cycle
                    r_tcnt <= w_tlast ? '0 : r_tcnt + TW'(1);
                    r_tv   <= 1'b1;
                    r_tl   <= w_tlast;
                    if (r_tv) begin
                        r_next <= r_next | w_tbit;
                        if (r_tl) begin
                            r_set  <= r_next | w_tbit;
                            r_scnt <= '0;
                            r_ev   <= 1'b0;
                            r_chg  <= 1'b0;
                        end
                    end
                end
                nsm_pkg::ST_CLOSE: begin
                    // sweep the epsilon masks until a sweep adds nothing
                    r_scnt <= w_slast ? '0 : r_scnt + SW'(1);
                    r_eidx <= r_scnt;
                    r_ev   <= 1'b1;
                    r_el   <= w_slast;
                    if (r_ev) begin
                        r_set <= r_set | w_add;
                        if (w_grow) r_chg <= 1'b1;
                        if (r_el) begin
                            if (r_chg || w_grow) begin
                                r_scnt <= '0;
                                r_ev   <= 1'b0;
                                r_chg  <= 1'b0;
                            end else begin
                                r_opening <= 1'b0;
                                r_tcnt    <= '0;
                                r_tv      <= 1'b0;
                                r_next    <= '0;
                            end
                        end
                    end
                end
                nsm_pkg::ST_DONE: begin
                    // hold until the result register is free, then close the string
                    if (w_out_free) begin
                        r_mvld                <= 1'b1;
                        r_mdata.pad           <= '0;
                        r_mdata.matched       <= |(r_set & w_acc_set);
                        r_mdata.final_states  <= nsm_pkg::SET_W'(r_set);
                        r_set                 <= '0;
                        r_open                <= 1'b0;
                    end
                end
                default: begin
                    r_open <= 1'b0;
                end
            endcase
        end
    end

    // Checks
    a_scan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsm_pkg::ST_SCAN) |-> r_open)
        else $error("table scan without an open string");

    a_finish_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_op == nsm_pkg::OP_FINISH))
        |=> ((r_state == nsm_pkg::ST_DONE) || (r_state == nsm_pkg::ST_CLOSE)))
        else $error("finish item did not reach result stage");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == nsm_pkg::ST_DONE) && w_out_free) |=> (m_axis_tvalid && !r_open))
        else $error("result not loaded at string end");

endmodule

### verif/tb_nfa_string_matcher_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the automaton string matcher. Items are driven onto the
// input stream with random gaps, a behavioural copy of the automaton runs on every
// accepted item and queues the verdict of each finished string, and every result
// item is compared field by field against the oldest queued verdict. The result
// side stalls at random and, once, holds off long enough to back up the input.
module tb_nfa_string_matcher_core;

    localparam int NSTATES      = 16;
    localparam int NTRANS       = 64;
    // worst symbol on an open string: table scan plus up to NSTATES sweeps, with margin
    localparam int DRAIN_CYCLES = 400;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [nsm_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [nsm_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [nsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [nsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // behavioural copy of the automaton
    nsm_pkg::t_entry           trans_tab [NTRANS];
    logic [nsm_pkg::SET_W-1:0] eps_tab [NSTATES];
    logic [3:0]                start_reg;
    logic [nsm_pkg::SET_W-1:0] accept_reg;
    logic [nsm_pkg::SET_W-1:0] run_set;
    logic                      run_open;
    nsm_pkg::t_out_data        verdict_q [$];

    // stimulus and handshake control
    logic [7:0]         alpha [3];
    bit                 tx_jitter;
    bit                 rx_jitter;
    int                 tx_calm;
    int                 rx_calm;
    int                 stall_left;
    int                 hold_left;
    int                 items_sent;
    int                 err_cnt;
    nsm_pkg::t_out_data seen;
    nsm_pkg::t_out_data want;

    nfa_string_matcher_core #(
        .NUM_STATES      (NSTATES),
        .NUM_TRANSITIONS (NTRANS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Epsilon closure: add empty-move targets until the set stops growing
    function automatic logic [nsm_pkg::SET_W-1:0] close_set(
        input logic [nsm_pkg::SET_W-1:0] s);
        logic [nsm_pkg::SET_W-1:0] prev;
        do begin
            prev = s;
            for (int i = 0; i < NSTATES; i++)
                if (s[i])
                    s |= eps_tab[i];
        end while (s != prev);
        return s;
    endfunction

    // Advance the automaton copy by one accepted item
    function automatic void advance_automaton(input nsm_pkg::t_op op,
                                              input nsm_pkg::t_in_data d);
        logic [nsm_pkg::SET_W-1:0] nxt;
        nsm_pkg::t_out_data        res;
        case (op)
            nsm_pkg::OP_WRITE_ENTRY: begin
                trans_tab[d.entry_index] = '{valid: d.entry_valid, from_state: d.from_state,
                                             to_state: d.to_state, label: d.symbol};
            end
            nsm_pkg::OP_WRITE_EPS: begin
                eps_tab[d.from_state] = d.epsilon_targets;
            end
            default: begin
                // open a string on its first symbol or finish
                if (!run_open) begin
                    run_set  = close_set(nsm_pkg::SET_W'(1) << start_reg);
                    run_open = 1'b1;
                end
                if (op == nsm_pkg::OP_SYMBOL) begin
                    nxt = '0;
                    foreach (trans_tab[k])
                        if (trans_tab[k].valid && trans_tab[k].label == d.symbol &&
                            run_set[trans_tab[k].from_state])
                            nxt[trans_tab[k].to_state] = 1'b1;
                    run_set = close_set(nxt);
                end else begin
                    res              = '0;
                    res.matched      = |(run_set & accept_reg);
                    res.final_states = run_set;
                    verdict_q.push_back(res);
                    run_set  = '0;
                    run_open = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic nsm_pkg::t_in_data rand_payload();
        logic [63:0]       r;
        nsm_pkg::t_in_data d;
        r     = {$urandom(), $urandom()};
        d     = r[nsm_pkg::IN_TDATA_W-1:0];
        d.pad = 1'b0;
        return d;
    endfunction

    function automatic logic [nsm_pkg::SET_W-1:0] sparse_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return nsm_pkg::SET_W'(1) << $urandom_range(0, NSTATES - 1);
            2:       return (nsm_pkg::SET_W'(1) << $urandom_range(0, NSTATES - 1)) |
                            (nsm_pkg::SET_W'(1) << $urandom_range(0, NSTATES - 1));
            default: return nsm_pkg::SET_W'($urandom) & nsm_pkg::SET_W'($urandom);
        endcase
    endfunction

    task automatic log_fault(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Offer one item, hold it until accepted, then update the automaton copy
    task automatic send_item(input nsm_pkg::t_op op, input nsm_pkg::t_in_data d);
        int gap;
        gap = 0;
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (tx_jitter && $urandom_range(0, 2) == 0) begin
            gap     = $urandom_range(1, 13);
            tx_calm = $urandom_range(0, 1) ? $urandom_range(5, 30) : 0;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_automaton(op, d);
        items_sent++;
    endtask

    task automatic put_entry(input logic [nsm_pkg::INDEX_W-1:0] idx, input logic vld,
                             input logic [3:0] src, input logic [3:0] dst,
                             input logic [7:0] lab);
        nsm_pkg::t_in_data d;
        d             = rand_payload();
        d.entry_index = idx;
        d.entry_valid = vld;
        d.from_state  = src;
        d.to_state    = dst;
        d.symbol      = lab;
        send_item(nsm_pkg::OP_WRITE_ENTRY, d);
    endtask

    task automatic put_eps(input logic [3:0] src, input logic [nsm_pkg::SET_W-1:0] mask);
        nsm_pkg::t_in_data d;
        d                 = rand_payload();
        d.from_state      = src;
        d.epsilon_targets = mask;
        send_item(nsm_pkg::OP_WRITE_EPS, d);
    endtask

    task automatic put_symbol(input logic [7:0] sym);
        nsm_pkg::t_in_data d;
        d        = rand_payload();
        d.symbol = sym;
        send_item(nsm_pkg::OP_SYMBOL, d);
    endtask

    task automatic put_finish();
        send_item(nsm_pkg::OP_FINISH, rand_payload());
    endtask

    // Drop the input, wait for every verdict, then let the block run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [nsm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [nsm_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == nsm_pkg::REG_START_STATE)
            start_reg = val[3:0];
        else
            accept_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_random_automaton();
        int shape;
        shape = $urandom_range(0, 5);
        foreach (alpha[k])
            alpha[k] = 8'($urandom_range(1, 255));
        repeat ($urandom_range(6, 20))
            put_entry(nsm_pkg::INDEX_W'($urandom), $urandom_range(0, 7) != 0, 4'($urandom),
                      4'($urandom), alpha[$urandom_range(0, 2)]);
        if (shape == 0) begin
            // descending chain of empty moves: slowest closure
            for (int s = 0; s < NSTATES; s++)
                put_eps(4'(s), (s == 0) ? '0 : nsm_pkg::SET_W'(1) << (s - 1));
        end else if (shape == 1) begin
            for (int s = 0; s < NSTATES; s++)
                put_eps(4'(s), '0);
        end else begin
            repeat ($urandom_range(2, 6))
                put_eps(4'($urandom), sparse_mask());
        end
    endtask

    // Mostly in-alphabet bytes, now and then a stray byte or a table write
    task automatic run_random_string();
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1))
                    put_entry(nsm_pkg::INDEX_W'($urandom), 1'($urandom), 4'($urandom),
                              4'($urandom), 8'($urandom_range(1, 255)));
                else
                    put_eps(4'($urandom), sparse_mask());
            end
            if ($urandom_range(0, 6) == 0)
                put_symbol(8'($urandom_range(1, 255)));
            else
                put_symbol(alpha[$urandom_range(0, 2)]);
        end
        put_finish();
    endtask

    // Empty table and default registers straight after reset
    task automatic test_reset_state();
        put_finish();
        put_symbol(8'($urandom_range(1, 255)));
        put_finish();
    endtask

    // Hand-built automaton: accept, reject, dead set, byte zero, cleared entry
    task automatic test_directed_paths();
        settle();
        write_reg(nsm_pkg::REG_START_STATE, 16'h0000);
        write_reg(nsm_pkg::REG_ACCEPTING, 16'h8000);
        put_entry(6'd0, 1'b1, 4'd0, 4'd1, 8'h61);
        put_entry(6'd63, 1'b1, 4'd15, 4'd15, 8'hFF);
        put_entry(6'd1, 1'b1, 4'd1, 4'd14, 8'h00);
        put_eps(4'd1, 16'h8000);
        put_symbol(8'h61);
        put_symbol(8'hFF);
        put_finish();
        put_symbol(8'h61);
        put_symbol(8'h00);
        put_finish();
        // no entry for the first byte: set goes empty and stays so
        put_symbol(8'h62);
        put_symbol(8'h61);
        put_finish();
        put_entry(6'd0, 1'b0, 4'd0, 4'd1, 8'h61);
        put_symbol(8'h61);
        put_finish();
    endtask

    // Highest start state whose closure covers every state
    task automatic test_start_closure();
        settle();
        write_reg(nsm_pkg::REG_START_STATE, 16'hFFFF);
        write_reg(nsm_pkg::REG_ACCEPTING, 16'h0001);
        put_eps(4'd15, 16'hFFFF);
        put_finish();
        put_eps(4'd15, 16'h0000);
    endtask

    // Table write inside a string, accepting set changed before its finish
    task automatic test_accept_at_finish();
        put_symbol(8'hFF);
        put_entry(6'd2, 1'b1, 4'd15, 4'd3, 8'h33);
        put_symbol(8'h33);
        settle();
        write_reg(nsm_pkg::REG_ACCEPTING, 16'h0008);
        put_finish();
    endtask

    task automatic test_random_automata(input int budget);
        int stop_at;
        int phase;
        stop_at = items_sent + budget;
        phase   = 0;
        while (items_sent < stop_at) begin
            settle();
            case (phase % 4)
                0:       write_reg(nsm_pkg::REG_START_STATE, {12'($urandom), 4'd0});
                1:       write_reg(nsm_pkg::REG_START_STATE, {12'($urandom), 4'd15});
                default: write_reg(nsm_pkg::REG_START_STATE, 16'($urandom));
            endcase
            case (phase % 4)
                0:       write_reg(nsm_pkg::REG_ACCEPTING, 16'hFFFF);
                1:       write_reg(nsm_pkg::REG_ACCEPTING, 16'h0000);
                default: write_reg(nsm_pkg::REG_ACCEPTING, sparse_mask() | 16'($urandom));
            endcase
            load_random_automaton();
            repeat ($urandom_range(4, 10)) run_random_string();
            phase++;
        end
    endtask

    // Hold the result side off while strings keep coming, so the input backs up
    task automatic test_input_stall();
        tx_jitter = 1'b0;
        hold_left = 600;
        repeat (10) begin
            put_symbol(alpha[$urandom_range(0, 2)]);
            put_finish();
        end
        tx_jitter = 1'b1;
    endtask

    task automatic test_calm_tail();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        test_random_automata(80);
    endtask

    // Result side: random stall bursts, quiet stretches, one long hold-off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 13);
                    rx_calm    = $urandom_range(0, 1) ? $urandom_range(10, 60) : 0;
                end
            end
        end
    end

    // Compare each result item with the oldest verdict
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            seen = m_axis_tdata;
            if (verdict_q.size() == 0) begin
                log_fault($sformatf("result with nothing outstanding: %h", seen));
            end else begin
                want = verdict_q.pop_front();
                if (seen.matched !== want.matched)
                    log_fault($sformatf("matched: expected %0d, got %0d",
                                        want.matched, seen.matched));
                if (seen.final_states !== want.final_states)
                    log_fault($sformatf("final_states: expected %h, got %h",
                                        want.final_states, seen.final_states));
            end
        end
    end

    initial begin
        #(64'd20_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= nsm_pkg::OP_WRITE_ENTRY;
        tx_jitter  = 1'b1;
        rx_jitter  = 1'b1;
        start_reg  = '0;
        accept_reg = '0;
        run_set    = '0;
        run_open   = 1'b0;
        foreach (trans_tab[k])
            trans_tab[k] = '0;
        foreach (eps_tab[k])
            eps_tab[k] = '0;
        foreach (alpha[k])
            alpha[k] = 8'h61;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_paths();
        test_start_closure();
        test_accept_at_finish();
        test_random_automata(620);
        test_input_stall();
        test_calm_tail();

        settle();
        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
